### rtl/core/robin_hood_int_hash_table_defines.svh
// ----------------------------------------------------------------------------
// Robin Hood hash table assertion macros
// Shared property wrappers used by the RTL files of the hash table.
// ----------------------------------------------------------------------------
`ifndef ROBIN_HOOD_INT_HASH_TABLE_DEFINES_SVH
`define ROBIN_HOOD_INT_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHIH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhih: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHIH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhih: next-cycle check failed");

`endif

### rtl/core/rhih_pkg.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Sizes, operation codes, payload and slot types shared by the table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rhih_pkg;

    // Table size; must be a power of two so that the slot index wraps.
    localparam int SLOTS   = 1024;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int LIM_W   = 10;
    localparam int ENTRY_W = 10;
    localparam int CMP_W   = (IDX_W > LIM_W) ? IDX_W : LIM_W;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(768);
    localparam logic [63:0]      GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [1:0] ACT_GET = 2'd0;
    localparam logic [1:0] ACT_PUT = 2'd1;
    localparam logic [1:0] ACT_DEL = 2'd2;
    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   read_value;
        logic               status;
        logic [ENTRY_W-1:0] entry_total;
    } t_rsp;

    typedef struct packed {
        logic             used;
        logic [IDX_W-1:0] distance;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] rd_addr;
        t_slot            wr_data;
    } t_ram_cmd;

    typedef struct packed {
        logic empty;    // slot holds no entry
        logic key_eq;   // slot key equals the probe key
        logic closer;   // slot distance is below the probe distance
        logic at_home;  // slot entry sits in its home slot
    } t_cmp;

    // Only the low index bits of the product are needed, and those depend
    // only on the low bits of both factors.
    function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
        logic [IDX_W-1:0] p;
        p = k[IDX_W-1:0] * GOLDEN_MULT[IDX_W-1:0];
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rhih_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhih_slot_ram
    import rhih_pkg::*;
(
    input  wire      i_clk,
    input  t_ram_cmd i_cmd,
    output t_slot    o_q
);

    t_slot r_mem [SLOTS];
    t_slot r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_q <= r_mem[i_cmd.rd_addr];
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

### rtl/core/rhih_slot_cmp.sv
// ----------------------------------------------------------------------------
// Slot compare unit
// Compares the slot just read against the probe key and probe distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhih_slot_cmp
    import rhih_pkg::*;
(
    input  t_slot            i_slot,
    input  wire [KEY_W-1:0]  i_key,
    input  wire [IDX_W-1:0]  i_dist,
    output t_cmp             o_cmp
);

    always_comb begin
        o_cmp.empty   = !i_slot.used;
        o_cmp.key_eq  = (i_slot.key == i_key);
        o_cmp.closer  = (i_slot.distance < i_dist);
        o_cmp.at_home = (i_slot.distance == '0);
    end

endmodule

`default_nettype wire

### rtl/core/rhih_seq.sv
// ----------------------------------------------------------------------------
// Probe sequencer
// Walks the slot memory one slot per cycle for get, put and delete, and runs
// the clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "robin_hood_int_hash_table_defines.svh"

module rhih_seq
    import rhih_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  t_req             i_req,
    input  wire [LIM_W-1:0]  i_limit,
    output logic             o_idle,
    output logic             o_done,
    output t_rsp             o_rsp,
    input  wire              i_take,
    output t_ram_cmd         o_cmd,
    input  t_slot            i_q
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_INS   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_clr,   n_clr;
    logic [IDX_W-1:0] r_cnt,   n_cnt;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [IDX_W-1:0] r_prev,  n_prev;
    logic [IDX_W-1:0] r_dist,  n_dist;
    logic [KEY_W-1:0] r_key,   n_key;
    logic [VAL_W-1:0] r_val,   n_val;
    logic [1:0]       r_act,   n_act;
    logic             r_found, n_found;
    logic [VAL_W-1:0] r_rv,    n_rv;
    logic             r_status, n_status;

    logic [IDX_W-1:0] nidx;
    logic [IDX_W-1:0] home;
    logic [CMP_W-1:0] lim_ext;
    logic [CMP_W-1:0] lim_cap;
    logic [CMP_W-1:0] lim_eff;
    logic             full;
    t_cmp             cmp;

    rhih_slot_cmp u_cmp (
        .i_slot (i_q),
        .i_key  (r_key),
        .i_dist (r_dist),
        .o_cmp  (cmp)
    );

    assign nidx    = r_idx + 1'b1;
    assign home    = home_slot(i_req.key);
    assign lim_ext = CMP_W'(i_limit);
    assign lim_cap = CMP_W'(SLOTS - 1);
    assign lim_eff = (lim_ext > lim_cap) ? lim_cap : lim_ext;
    assign full    = (CMP_W'(r_cnt) >= lim_eff);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_prev   = r_prev;
        n_dist   = r_dist;
        n_key    = r_key;
        n_val    = r_val;
        n_act    = r_act;
        n_found  = r_found;
        n_rv     = r_rv;
        n_status = r_status;

        o_cmd.wr_en            = 1'b0;
        o_cmd.wr_addr          = r_idx;
        o_cmd.rd_addr          = nidx;
        o_cmd.wr_data.used     = 1'b1;
        o_cmd.wr_data.distance = r_dist;
        o_cmd.wr_data.key      = r_key;
        o_cmd.wr_data.value    = r_val;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en        = 1'b1;
                o_cmd.wr_addr      = r_clr;
                o_cmd.rd_addr      = r_clr + 1'b1;
                o_cmd.wr_data.used = 1'b0;
                n_clr              = r_clr + 1'b1;
                if (r_clr == IDX_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.rd_addr = home;
                if (i_start) begin
                    n_idx    = home;
                    n_dist   = '0;
                    n_key    = i_req.key;
                    n_val    = i_req.value;
                    n_act    = i_req.action;
                    n_found  = 1'b0;
                    n_rv     = '0;
                    n_status = 1'b0;
                    unique case (i_req.action) inside
                        ACT_GET, ACT_DEL: begin
                            n_state = S_LOOK;
                        end
                        ACT_PUT: begin
                            // A full table rejects even a put that would update.
                            if (full) begin
                                n_status = 1'b1;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_INS;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                if (cmp.empty || cmp.closer) begin
                    n_state = S_DONE;
                end else if (cmp.key_eq) begin
                    n_found = 1'b1;
                    if (r_act == ACT_GET) begin
                        n_rv    = i_q.value;
                        n_state = S_DONE;
                    end else begin
                        // The read of the following slot is already under way.
                        n_cnt   = r_cnt - 1'b1;
                        n_prev  = r_idx;
                        n_idx   = nidx;
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_dist = r_dist + 1'b1;
                    n_idx  = nidx;
                end
            end
            S_INS: begin
                if (cmp.empty) begin
                    o_cmd.wr_en = 1'b1;
                    n_found     = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    n_state     = S_DONE;
                end else if (cmp.key_eq) begin
                    o_cmd.wr_en            = 1'b1;
                    o_cmd.wr_data.distance = i_q.distance;
                    n_state                = S_DONE;
                end else if (cmp.closer) begin
                    // Take the slot from the richer occupant and carry it on.
                    o_cmd.wr_en = 1'b1;
                    n_key       = i_q.key;
                    n_val       = i_q.value;
                    n_dist      = i_q.distance + 1'b1;
                    n_idx       = nidx;
                end else begin
                    n_dist = r_dist + 1'b1;
                    n_idx  = nidx;
                end
            end
            S_SHIFT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_prev;
                if (cmp.empty || cmp.at_home) begin
                    o_cmd.wr_data.used = 1'b0;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.wr_data.distance = i_q.distance - 1'b1;
                    o_cmd.wr_data.key      = i_q.key;
                    o_cmd.wr_data.value    = i_q.value;
                    n_prev                 = r_idx;
                    n_idx                  = nidx;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_prev   <= n_prev;
        r_dist   <= n_dist;
        r_key    <= n_key;
        r_val    <= n_val;
        r_act    <= n_act;
        r_found  <= n_found;
        r_rv     <= n_rv;
        r_status <= n_status;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_rsp.found       = r_found;
        o_rsp.read_value  = r_rv;
        o_rsp.status      = r_status;
        o_rsp.entry_total = ENTRY_W'(r_cnt);
    end

    // A write must never hit the slot whose read is issued in the same cycle.
    `RHIH_ASSERT_IMPL(a_wr_rd_apart, i_clk, i_rst_n, o_cmd.wr_en, (o_cmd.wr_addr != o_cmd.rd_addr))
    `RHIH_ASSERT_NEXT(a_idle_cnt_hold, i_clk, i_rst_n, (r_state == S_IDLE), (r_cnt == $past(r_cnt)))
    `RHIH_ASSERT_IMPL(a_found_xor_status, i_clk, i_rst_n, (r_state == S_DONE), !(r_found && r_status))

endmodule

`default_nettype wire

### rtl/core/robin_hood_int_hash_table.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table, 64-bit keys and values
// Open-addressing table with linear probing, insert by displacement and
// delete by backward shift; puts are rejected at the load limit.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+------------------------------
// in       | in  | i_in_valid / o_in_ready   | t_req: action, key, value
// out      | out | o_out_valid / i_out_ready | t_rsp: found, read_value,
//          |     |                           |        status, entry_total
// cfg      | in  | i_cfg_valid / o_cfg_ready | load_limit, 10 bits
//
// A request walks its slots one slot per cycle through the single memory read
// port, the deleted slot's run of shifted entries included. Put rejects and
// unused codes visit no slot. After reset a clearing pass writes every slot
// once before the first request is taken; configuration writes are taken
// throughout. The result waits in an output register, so a stalled output
// delays only the end of the following request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "robin_hood_int_hash_table_defines.svh"

module robin_hood_int_hash_table
    import rhih_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  t_req             i_in,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output t_rsp             o_out,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire [LIM_W-1:0]  i_cfg_data
);

    logic [LIM_W-1:0] r_limit;
    logic             r_out_valid;
    t_rsp             r_out;
    logic             seq_idle;
    logic             seq_done;
    logic             take;
    logic             start;
    t_rsp             seq_rsp;
    t_ram_cmd         ram_cmd;
    t_slot            ram_q;

    assign start = i_in_valid && seq_idle;
    assign take  = !r_out_valid || i_out_ready;

    rhih_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_in),
        .i_limit (r_limit),
        .o_idle  (seq_idle),
        .o_done  (seq_done),
        .o_rsp   (seq_rsp),
        .i_take  (take),
        .o_cmd   (ram_cmd),
        .i_q     (ram_q)
    );

    rhih_slot_ram u_ram (
        .i_clk (i_clk),
        .i_cmd (ram_cmd),
        .o_q   (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (seq_done && take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done && take) begin
            r_out <= seq_rsp;
        end
    end

    assign o_in_ready  = seq_idle;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Only a get hit returns a stored value.
    `RHIH_ASSERT_IMPL(a_rv_zero_on_miss, i_clk, i_rst_n, (r_out_valid && !r_out.found), (r_out.read_value == '0))

endmodule

`default_nettype wire
